[design/wcta_pkg.sv]
// ----------------------------------------------------------------------------
// wcta_pkg
// shared constants, codes and transaction types of the wall column texel
// address block
// ----------------------------------------------------------------------------
package wcta_pkg;

   // screen geometry and fixed scale factors of the texel row mapping
   localparam int SCREEN_HEIGHT = 512;
   localparam int HALF_ROWS     = SCREEN_HEIGHT / 2;
   localparam int ROW_SCALE     = 256;
   localparam int HALF_SCALE    = 128;
   localparam int ROW_SHIFT     = $clog2(ROW_SCALE);
   localparam int HALF_SHIFT    = $clog2(HALF_SCALE);

   // field widths
   localparam int COL_W   = 10;
   localparam int ROW_W   = 9;
   localparam int HGT_W   = 16;
   localparam int DIR_W   = 32;
   localparam int FIX_W   = 31;
   localparam int DIM_W   = 13;
   localparam int TEX_W   = 12;
   localparam int NUM_TEX = 4;

   // texel row arithmetic: span position up to 256*h, product with the
   // texture height below 2^36, quotient at most 256*height
   localparam int SPAN_W   = 24;
   localparam int PROD_T_W = 36;
   localparam int QUO_W    = 21;

   // bus widths
   localparam int REQ_DATA_W = 192;
   localparam int RSP_DATA_W = 48;
   localparam int CSR_IDX_W  = 8;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [DIM_W-1:0] DIM_MIN   = DIM_W'(1);
   localparam logic [DIM_W-1:0] DIM_MAX   = DIM_W'(4096);
   localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(64);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NORTH_WIDTH  = 8'd0,
      CSR_SOUTH_WIDTH  = 8'd1,
      CSR_EAST_WIDTH   = 8'd2,
      CSR_WEST_WIDTH   = 8'd3,
      CSR_NORTH_HEIGHT = 8'd4,
      CSR_SOUTH_HEIGHT = 8'd5,
      CSR_EAST_HEIGHT  = 8'd6,
      CSR_WEST_HEIGHT  = 8'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      SRC_CEILING = 2'd0,
      SRC_FLOOR   = 2'd1,
      SRC_WALL    = 2'd2
   } source_type;

   typedef enum logic [1:0] {
      TEX_NORTH = 2'd0,
      TEX_SOUTH = 2'd1,
      TEX_EAST  = 2'd2,
      TEX_WEST  = 2'd3
   } tex_id_type;

   typedef struct packed {
      logic [NUM_TEX-1:0][DIM_W-1:0] width;
      logic [NUM_TEX-1:0][DIM_W-1:0] height;
   } tex_dims_type;

   typedef struct packed {
      logic [COL_W-1:0] column;
      logic [ROW_W-1:0] row;
      source_type       source;
      tex_id_type       tex_id;
   } meta_type;

   // classified pixel, passed from the front end to the texel pipeline
   typedef struct packed {
      meta_type         meta;
      logic [HGT_W-1:0] height_px;
      logic [SPAN_W-1:0] span_pos;
      logic [DIM_W-1:0] tex_width;
      logic [DIM_W-1:0] tex_height;
      logic [FIX_W-1:0] pos;
      logic [DIR_W-1:0] dir;
      logic [FIX_W-1:0] distance;
   } job_type;

   typedef struct packed {
      meta_type         meta;
      logic [TEX_W-1:0] texel_x;
      logic [TEX_W-1:0] texel_y;
   } result_type;

endpackage

[design/wcta_csr.sv]
// ----------------------------------------------------------------------------
// wcta_csr
// texture dimension registers with clamping on write
// ----------------------------------------------------------------------------
module wcta_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [wcta_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [wcta_pkg::DIM_W-1:0]     csr_data,
   output wcta_pkg::tex_dims_type         dims
);
   import wcta_pkg::*;

   logic [NUM_TEX-1:0][DIM_W-1:0] width_ff, width_in;
   logic [NUM_TEX-1:0][DIM_W-1:0] height_ff, height_in;
   logic [DIM_W-1:0]              dim_in;

   assign csr_ready = 1'b1;

   always_comb begin
      if (csr_data < DIM_MIN) begin
         dim_in = DIM_MIN;
      end else if (csr_data > DIM_MAX) begin
         dim_in = DIM_MAX;
      end else begin
         dim_in = csr_data;
      end
   end

   // unknown indexes fall through and leave every register alone
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_NORTH_WIDTH:  width_in[TEX_NORTH]  = dim_in;
            CSR_SOUTH_WIDTH:  width_in[TEX_SOUTH]  = dim_in;
            CSR_EAST_WIDTH:   width_in[TEX_EAST]   = dim_in;
            CSR_WEST_WIDTH:   width_in[TEX_WEST]   = dim_in;
            CSR_NORTH_HEIGHT: height_in[TEX_NORTH] = dim_in;
            CSR_SOUTH_HEIGHT: height_in[TEX_SOUTH] = dim_in;
            CSR_EAST_HEIGHT:  height_in[TEX_EAST]  = dim_in;
            CSR_WEST_HEIGHT:  height_in[TEX_WEST]  = dim_in;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= {NUM_TEX{DIM_RESET}};
         height_ff <= {NUM_TEX{DIM_RESET}};
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign dims.width  = width_ff;
   assign dims.height = height_ff;

endmodule

[design/wcta_front.sv]
// ----------------------------------------------------------------------------
// wcta_front
// pixel classifier: wall span clamp, ceiling or floor or wall, texture pick
// ----------------------------------------------------------------------------
module wcta_front (
   input  logic [wcta_pkg::COL_W-1:0] column,
   input  logic [wcta_pkg::ROW_W-1:0] row,
   input  logic [wcta_pkg::HGT_W-1:0] wall_height,
   input  logic                       hit_side,
   input  logic [wcta_pkg::DIR_W-1:0] dir_x,
   input  logic [wcta_pkg::DIR_W-1:0] dir_y,
   input  logic [wcta_pkg::FIX_W-1:0] distance,
   input  logic [wcta_pkg::FIX_W-1:0] pos_x,
   input  logic [wcta_pkg::FIX_W-1:0] pos_y,
   input  wcta_pkg::tex_dims_type     dims,
   output wcta_pkg::job_type          job
);
   import wcta_pkg::*;

   logic [HGT_W-1:0]  h_eff;
   logic [HGT_W-1:0]  half_h;
   logic [HGT_W:0]    mid_sum;
   logic [HGT_W:0]    span_top;
   logic [HGT_W:0]    span_bot;
   logic [HGT_W:0]    row_ext;
   logic              in_span;
   logic [SPAN_W:0]   span_sum;
   source_type        source;
   tex_id_type        tex_id;

   // zero height counts as one pixel
   assign h_eff   = (wall_height == '0) ? HGT_W'(1) : wall_height;
   assign half_h  = h_eff >> 1;
   assign mid_sum = (HGT_W+1)'(HALF_ROWS) + (HGT_W+1)'(half_h);
   assign row_ext = (HGT_W+1)'(row);

   always_comb begin
      if (half_h >= HGT_W'(HALF_ROWS)) begin
         span_top = '0;
      end else begin
         span_top = (HGT_W+1)'(HALF_ROWS) - (HGT_W+1)'(half_h);
      end
      if (mid_sum >= (HGT_W+1)'(SCREEN_HEIGHT)) begin
         span_bot = (HGT_W+1)'(SCREEN_HEIGHT - 1);
      end else begin
         span_bot = mid_sum;
      end
   end

   assign in_span = (row_ext >= span_top) && (row_ext <= span_bot);

   always_comb begin
      if (in_span) begin
         source = SRC_WALL;
      end else if (row_ext < (HGT_W+1)'(HALF_ROWS)) begin
         source = SRC_CEILING;
      end else begin
         source = SRC_FLOOR;
      end
      if (!hit_side) begin
         tex_id = dir_x[DIR_W-1] ? TEX_WEST : TEX_EAST;
      end else begin
         tex_id = dir_y[DIR_W-1] ? TEX_NORTH : TEX_SOUTH;
      end
   end

   // 256*row - 128*screen_height + 128*h, never negative inside the span
   assign span_sum = ((SPAN_W+1)'(row) << ROW_SHIFT)
                   + ((SPAN_W+1)'(h_eff) << HALF_SHIFT)
                   - (SPAN_W+1)'(HALF_SCALE * SCREEN_HEIGHT);

   always_comb begin
      job.meta.column = column;
      job.meta.row    = row;
      job.meta.source = source;
      job.meta.tex_id = tex_id;
      job.height_px   = h_eff;
      job.span_pos    = span_sum[SPAN_W-1:0];
      job.tex_width   = dims.width[tex_id];
      job.tex_height  = dims.height[tex_id];
      job.distance    = distance;
      if (!hit_side) begin
         job.pos = pos_y;
         job.dir = dir_y;
      end else begin
         job.pos = pos_x;
         job.dir = dir_x;
      end
   end

endmodule

[design/wcta_queue.sv]
// ----------------------------------------------------------------------------
// wcta_queue
// small job queue between the classifier and the texel pipeline
// ----------------------------------------------------------------------------
module wcta_queue #(
   parameter int DEPTH = wcta_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  wcta_pkg::job_type push_job,
   output logic              pop_valid,
   input  logic              pop_ready,
   output wcta_pkg::job_type pop_job
);
   import wcta_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_job    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[design/wcta_back.sv]
// ----------------------------------------------------------------------------
// wcta_back
// texel pipeline: wall hit fraction times width, pipelined divider for the
// texel row, output register
// ----------------------------------------------------------------------------
module wcta_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   output logic                 job_ready,
   input  wcta_pkg::job_type    job,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output wcta_pkg::result_type rsp
);
   import wcta_pkg::*;

   localparam int XPROD_W = 2 * DIR_W;
   localparam int FRAC_W  = 32;
   localparam int POS_PAD = XPROD_W - FIX_W - 16;
   localparam int TXP_W   = FRAC_W + DIM_W;
   localparam int Q_W     = QUO_W - ROW_SHIFT;

   typedef struct packed {
      meta_type         meta;
      logic [TEX_W-1:0] tx;
      logic [DIM_W-1:0] tex_height;
      logic [HGT_W-1:0] height_px;
      logic [HGT_W-1:0] rem;
      logic [QUO_W-1:0] quo;
   } div_stage_type;

   // one restoring step: bring down the next dividend bit, subtract if it fits
   function automatic div_stage_type div_step(input div_stage_type s);
      logic [HGT_W:0] trial;
      logic [HGT_W:0] diff;
      logic           fits;
      div_stage_type  r;
      r     = s;
      trial = {s.rem, s.quo[QUO_W-1]};
      diff  = trial - {1'b0, s.height_px};
      fits  = (trial >= {1'b0, s.height_px});
      r.rem = fits ? diff[HGT_W-1:0] : trial[HGT_W-1:0];
      r.quo = {s.quo[QUO_W-2:0], fits};
      return r;
   endfunction

   logic advance;

   // stage 0: products
   logic                      p0_valid_ff, p0_valid_in;
   logic signed [XPROD_W-1:0] p0_xprod_ff, p0_xprod_in;
   logic [SPAN_W+DIM_W-1:0]   tprod_full;
   logic [PROD_T_W-1:0]       p0_tprod_ff, p0_tprod_in;
   logic [FIX_W-1:0]          p0_pos_ff, p0_pos_in;
   logic [DIM_W-1:0]          p0_width_ff, p0_width_in;
   logic [DIM_W-1:0]          p0_height_ff, p0_height_in;
   logic [HGT_W-1:0]          p0_hpx_ff, p0_hpx_in;
   meta_type                  p0_meta_ff, p0_meta_in;

   // stage 1: wall hit fraction, divider set-up
   logic                      p1_valid_ff, p1_valid_in;
   logic signed [XPROD_W-1:0] wall_pos;
   logic [FRAC_W-1:0]         p1_frac_ff, p1_frac_in;
   logic [DIM_W-1:0]          p1_width_ff, p1_width_in;
   div_stage_type             p1_st_ff, p1_st_in;

   // divider stages, the first one also forms the texel column
   logic [TXP_W-1:0]          tx_prod;
   logic [QUO_W-1:0]          st_valid_ff, st_valid_in;
   div_stage_type             st_ff [QUO_W];
   div_stage_type             st_in [QUO_W];

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   result_type                rsp_ff, rsp_in;
   div_stage_type             last;
   logic [Q_W-1:0]            ty_quo;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign job_ready = advance;

   assign tprod_full = job.span_pos * job.tex_height;

   always_comb begin
      p0_valid_in  = job_valid;
      p0_xprod_in  = $signed({1'b0, job.distance}) * $signed(job.dir);
      p0_tprod_in  = tprod_full[PROD_T_W-1:0];
      p0_pos_in    = job.pos;
      p0_width_in  = job.tex_width;
      p0_height_in = job.tex_height;
      p0_hpx_in    = job.height_px;
      p0_meta_in   = job.meta;
   end

   // exact wall coordinate in q32.32, only the low word of its magnitude matters
   assign wall_pos = $signed({{POS_PAD{1'b0}}, p0_pos_ff, 16'b0}) + p0_xprod_ff;

   always_comb begin
      p1_valid_in = p0_valid_ff;
      p1_frac_in  = wall_pos[XPROD_W-1] ? (FRAC_W'(0) - wall_pos[FRAC_W-1:0])
                                        : wall_pos[FRAC_W-1:0];
      p1_width_in = p0_width_ff;
      p1_st_in.meta       = p0_meta_ff;
      p1_st_in.tx         = '0;
      p1_st_in.tex_height = p0_height_ff;
      p1_st_in.height_px  = p0_hpx_ff;
      p1_st_in.rem        = HGT_W'(p0_tprod_ff[PROD_T_W-1:QUO_W]);
      p1_st_in.quo        = p0_tprod_ff[QUO_W-1:0];
   end

   assign tx_prod = p1_frac_ff * p1_width_ff;

   always_comb begin
      st_in[0]    = div_step(p1_st_ff);
      st_in[0].tx = tx_prod[FRAC_W+TEX_W-1:FRAC_W];
      for (int k = 1; k < QUO_W; k++) begin
         st_in[k] = div_step(st_ff[k-1]);
      end
      st_valid_in = {st_valid_ff[QUO_W-2:0], p1_valid_ff};
   end

   // quotient of the full division by h, then by 256; the result never
   // exceeds the texture height, so the modulo is one compare
   assign last   = st_ff[QUO_W-1];
   assign ty_quo = last.quo[QUO_W-1:ROW_SHIFT];

   always_comb begin
      rsp_valid_in = st_valid_ff[QUO_W-1];
      rsp_in.meta  = last.meta;
      if (last.meta.source == SRC_WALL) begin
         rsp_in.texel_x = last.tx;
         rsp_in.texel_y = (ty_quo == last.tex_height) ? '0 : ty_quo[TEX_W-1:0];
      end else begin
         rsp_in.meta.tex_id = TEX_NORTH;
         rsp_in.texel_x     = '0;
         rsp_in.texel_y     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_valid_ff  <= 1'b0;
         p1_valid_ff  <= 1'b0;
         st_valid_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         p0_valid_ff  <= p0_valid_in;
         p1_valid_ff  <= p1_valid_in;
         st_valid_ff  <= st_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p0_xprod_ff  <= p0_xprod_in;
         p0_tprod_ff  <= p0_tprod_in;
         p0_pos_ff    <= p0_pos_in;
         p0_width_ff  <= p0_width_in;
         p0_height_ff <= p0_height_in;
         p0_hpx_ff    <= p0_hpx_in;
         p0_meta_ff   <= p0_meta_in;
         p1_frac_ff   <= p1_frac_in;
         p1_width_ff  <= p1_width_in;
         p1_st_ff     <= p1_st_in;
         for (int k = 0; k < QUO_W; k++) begin
            st_ff[k] <= st_in[k];
         end
         rsp_ff       <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

[design/wall_column_texel_address.sv]
// ----------------------------------------------------------------------------
// wall_column_texel_address
// texel addresser for one raycast screen pixel per transaction
// path from an accepted request to rsp_tvalid: the queue slot, 2 product and
//   fraction stages, 21 divider stages, then the output register
// throughput: one per cycle, fully pipelined divider; rsp_tready may stall
// reset: synchronous, clears the queue and pipeline valids, sizes back to 64
// ----------------------------------------------------------------------------
module wall_column_texel_address #(
   parameter int QUEUE_DEPTH = wcta_pkg::QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   // request stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // column[9:0] row[18:10] wall_height[34:19] dir_x[66:35] dir_y[98:67]
   // distance[129:99] pos_x[160:130] pos_y[191:161]
   input  logic [wcta_pkg::REQ_DATA_W-1:0] req_tdata,
   // hit_side[0]
   input  logic                            req_tuser,
   // response stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // out_column[9:0] out_row[18:10] texture_id[20:19] texel_x[32:21]
   // texel_y[44:33], zeros above
   output logic [wcta_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // source[1:0]
   output logic [1:0]                      rsp_tuser,
   // texture size register writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [wcta_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wcta_pkg::DIM_W-1:0]      csr_data
);
   import wcta_pkg::*;

   tex_dims_type dims;
   job_type      front_job;
   job_type      queue_job;
   logic         queue_valid;
   logic         back_ready;
   result_type   result;

   // texture widths and heights, clamped to 1..4096 on write
   wcta_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .dims      (dims)
   );

   // classify the pixel as it arrives: span clamp, source, texture choice
   wcta_front u_front (
      .column      (req_tdata[9:0]),
      .row         (req_tdata[18:10]),
      .wall_height (req_tdata[34:19]),
      .hit_side    (req_tuser),
      .dir_x       (req_tdata[66:35]),
      .dir_y       (req_tdata[98:67]),
      .distance    (req_tdata[129:99]),
      .pos_x       (req_tdata[160:130]),
      .pos_y       (req_tdata[191:161]),
      .dims        (dims),
      .job         (front_job)
   );

   // queue decouples request acceptance from pipeline stalls
   wcta_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_job   (front_job),
      .pop_valid  (queue_valid),
      .pop_ready  (back_ready),
      .pop_job    (queue_job)
   );

   // multipliers, divider and the response register
   wcta_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (queue_valid),
      .job_ready (back_ready),
      .job       (queue_job),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (result)
   );

   // pack the response transaction, padding to whole bytes
   assign rsp_tdata = {3'b000,
                       result.texel_y,
                       result.texel_x,
                       result.meta.tex_id,
                       result.meta.row,
                       result.meta.column};
   assign rsp_tuser = result.meta.source;

endmodule
